FILE: sv/kuf_pkg.sv
// Shared types, codes and constants for the keyed unique FIFO.
// No dependencies; every other file of the block imports this package.
package kuf_pkg;

    localparam int DEPTH = 16;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int DAT_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 3;

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef struct packed {
        logic                    we;
        logic [PTR_W-1:0]        addr;
        logic signed [KEY_W-1:0] key;
        logic signed [DAT_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic             re;
        logic [PTR_W-1:0] addr;
    } mem_rd_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

FILE: sv/kuf_if.sv
// Request and response channel interfaces of the keyed unique FIFO.
// Depends on kuf_pkg for field widths.
interface kuf_req_if;
    import kuf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] item_key;
    logic signed [DAT_W-1:0] item_data;

    modport source (output valid, op, item_key, item_data, input ready);
    modport sink   (input valid, op, item_key, item_data, output ready);
endinterface

interface kuf_rsp_if;
    import kuf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [KEY_W-1:0] out_key;
    logic signed [DAT_W-1:0] out_data;
    logic [CNT_W-1:0]        occupancy;

    modport source (output valid, status, out_key, out_data, occupancy, input ready);
    modport sink   (input valid, status, out_key, out_data, occupancy, output ready);
endinterface

FILE: sv/kuf_store.sv
// Key and data storage: one write port, one read port with registered data.
// Depends on kuf_pkg for widths and the port structs.
module kuf_store
(
    input  logic                             clk,
    input  kuf_pkg::mem_wr_t                 wr,
    input  kuf_pkg::mem_rd_t                 rd,
    output logic signed [kuf_pkg::KEY_W-1:0] rd_key,
    output logic signed [kuf_pkg::DAT_W-1:0] rd_data
);
    import kuf_pkg::*;

    logic signed [KEY_W-1:0] key_mem [DEPTH];
    logic signed [DAT_W-1:0] data_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            key_mem[wr.addr]  <= wr.key;
            data_mem[wr.addr] <= wr.data;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            rd_key  <= key_mem[rd.addr];
            rd_data <= data_mem[rd.addr];
        end
    end

endmodule

FILE: sv/keyed_unique_fifo.sv
// Top level of the keyed unique FIFO: sequencer, pointers and result register.
// Depends on kuf_pkg, kuf_req_if/kuf_rsp_if and kuf_store.
//
//  channel | dir | payload                                 | handshake
//  req     | in  | op, item_key, item_data                 | valid/ready
//  rsp     | out | status, out_key, out_data, occupancy    | valid/ready
//
// Enqueue and peek walk the held entries oldest first through one comparator,
// one entry a cycle, and stop at the first match or after the last entry.
// Dequeue and the unused op skip the walk. req.ready is high only between requests.
// A finished result waits in the output register; the next request is taken
// meanwhile, and only its own result stalls until rsp.ready frees the register.
// Reset empties the queue at once; stored words need no clearing.
module keyed_unique_fifo
(
    input  logic       clk,
    input  logic       rst_n,
    kuf_req_if.sink    req,
    kuf_rsp_if.source  rsp
);
    import kuf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_FINISH} state_t;

    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [DAT_W-1:0] data_reg, data_next;
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [PTR_W-1:0]        tail_reg, tail_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [PTR_W-1:0]        walk_reg, walk_next;
    logic [CNT_W-1:0]        issued_reg, issued_next;
    logic                    pending_reg, pending_next;
    logic                    found_reg, found_next;

    logic                    res_valid_reg, res_valid_next;
    logic [ST_W-1:0]         res_status_reg, res_status_next;
    logic signed [KEY_W-1:0] res_key_reg, res_key_next;
    logic signed [DAT_W-1:0] res_data_reg, res_data_next;
    logic [CNT_W-1:0]        res_occ_reg, res_occ_next;

    mem_wr_t                 mem_wr;
    mem_rd_t                 mem_rd;
    logic signed [KEY_W-1:0] rd_key;
    logic signed [DAT_W-1:0] rd_data;

    logic req_fire;
    logic hit;
    logic issue;
    logic fin_fire;

    kuf_store u_store
    (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_key  (rd_key),
        .rd_data (rd_data)
    );

    assign req.ready     = (state_reg == S_IDLE);
    assign req_fire      = req.valid && req.ready;
    assign rsp.valid     = res_valid_reg;
    assign rsp.status    = res_status_reg;
    assign rsp.out_key   = res_key_reg;
    assign rsp.out_data  = res_data_reg;
    assign rsp.occupancy = res_occ_reg;

    // single shared comparator against the word read last cycle
    assign hit      = (state_reg == S_SEARCH) && pending_reg && (rd_key == key_reg);
    assign issue    = (state_reg == S_SEARCH) && !hit && (issued_reg != count_reg);
    assign fin_fire = (state_reg == S_FINISH) && (!res_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        data_next       = data_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        walk_next       = walk_reg;
        issued_next     = issued_reg;
        pending_next    = pending_reg;
        found_next      = found_reg;
        res_valid_next  = res_valid_reg && !rsp.ready;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_data_next   = res_data_reg;
        res_occ_next    = res_occ_reg;
        mem_wr.we       = 1'b0;
        mem_wr.addr     = tail_reg;
        mem_wr.key      = key_reg;
        mem_wr.data     = data_reg;
        mem_rd.re       = 1'b0;
        mem_rd.addr     = walk_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next      = req.op;
                    key_next     = req.item_key;
                    data_next    = req.item_data;
                    walk_next    = head_reg;
                    issued_next  = '0;
                    pending_next = 1'b0;
                    found_next   = 1'b0;
                    if (req.op == OP_ENQ || req.op == OP_PEEK)
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        // dequeue reads the head now; data is ready in finish
                        mem_rd.re   = (req.op == OP_DEQ);
                        mem_rd.addr = head_reg;
                        state_next  = S_FINISH;
                    end
                end
            end
            S_SEARCH:
            begin
                mem_rd.re    = issue;
                mem_rd.addr  = walk_reg;
                pending_next = issue;
                if (issue)
                begin
                    walk_next   = next_ptr(walk_reg);
                    issued_next = issued_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    found_next = 1'b1;
                    state_next = S_FINISH;
                end
                else if (issued_reg == count_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (fin_fire)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = ST_OK;
                    res_key_next    = '0;
                    res_data_next   = '0;
                    res_occ_next    = count_reg;
                    unique case (op_reg)
                        OP_ENQ:
                        begin
                            if (found_reg)
                            begin
                                res_status_next = ST_DUP;
                            end
                            else if (count_reg == CNT_FULL)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr.we    = 1'b1;
                                tail_next    = next_ptr(tail_reg);
                                count_next   = count_reg + CNT_W'(1);
                                res_occ_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                res_key_next  = rd_key;
                                res_data_next = rd_data;
                                head_next     = next_ptr(head_reg);
                                count_next    = count_reg - CNT_W'(1);
                                res_occ_next  = count_reg - CNT_W'(1);
                            end
                        end
                        OP_PEEK:
                        begin
                            if (found_reg)
                            begin
                                res_key_next  = rd_key;
                                res_data_next = rd_data;
                            end
                            else
                            begin
                                res_status_next = ST_NOTFOUND;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            issued_reg    <= '0;
            pending_reg   <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            issued_reg    <= issued_next;
            pending_reg   <= pending_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        data_reg       <= data_next;
        walk_reg       <= walk_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_data_reg   <= res_data_next;
        res_occ_reg    <= res_occ_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("occupancy above capacity");

    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_FULL) |-> head_reg == tail_reg)
        else $error("pointers disagree with occupancy");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> issued_reg <= count_reg)
        else $error("search walked past the held entries");

    a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_fire && op_reg == OP_ENQ && !found_reg && count_reg != CNT_FULL)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("accepted enqueue did not grow the queue");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FINISH) |=> count_reg == $past(count_reg))
        else $error("occupancy changed outside the finish step");

endmodule
